@@ src/bos_pkg.sv @@
// ----------------------------------------------------------------------------
// bos_pkg
// Shared types and constants for the box overlap suppressor: controller
// states, the command and status groups between controller and datapath,
// and the configuration register map.
// ----------------------------------------------------------------------------
package bos_pkg;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_AGNOSTIC = 1'd1;

  localparam int unsigned THR_W = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd115;  // 0.45 of 256, rounded down
  localparam logic AGNOSTIC_RESET = 1'b0;

  // result count field width
  localparam int unsigned COUNT_OUT_W = 7;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming box, clear list on start_set
    logic scan;    // issue one kept-list read and advance the index
    logic finish;  // store the box if kept and room is left, and load the result register
  } bos_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;   // every stored entry has been read
    logic pipe_empty;  // no comparison in flight
    logic out_free;    // result register can take a new result
  } bos_status_t;

endpackage

@@ src/bos_ram.sv @@
// ----------------------------------------------------------------------------
// bos_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bos_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bos_ctrl.sv @@
// ----------------------------------------------------------------------------
// bos_ctrl
// Controller of the box overlap suppressor: accepts a box, sweeps the kept
// list through the comparison pipeline, waits for it to drain and hands the
// verdict to the result register.
// ----------------------------------------------------------------------------
module bos_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bos_pkg::bos_status_t status_i,
  output bos_pkg::bos_cmd_t    cmd_o
);

  bos_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bos_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bos_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bos_pkg::ST_SCAN;
        end
      end
      bos_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = bos_pkg::ST_DRAIN;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      bos_pkg::ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = bos_pkg::ST_FINISH;
        end
      end
      bos_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = bos_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bos_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/bos_datapath.sv @@
// ----------------------------------------------------------------------------
// bos_datapath
// Datapath of the box overlap suppressor: current box registers, kept-list
// index and count, a five stage overlap test pipeline fed by the kept-list
// RAM, and the result register.
// ----------------------------------------------------------------------------
module bos_datapath #(
  parameter int unsigned MAX_KEPT    = 64,
  parameter int unsigned COORD_WIDTH = 14,
  parameter int unsigned LABEL_WIDTH = 8,
  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  localparam int unsigned BW = 4 * COORD_WIDTH + LABEL_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bos_pkg::bos_cmd_t                 cmd_i,
  output bos_pkg::bos_status_t              status_o,
  // configuration
  input  logic [bos_pkg::THR_W-1:0]         thr_i,
  input  logic                              agnostic_i,
  // incoming box
  input  logic                              start_set_i,
  input  logic [COORD_WIDTH-1:0]            box_x_i,
  input  logic [COORD_WIDTH-1:0]            box_y_i,
  input  logic [COORD_WIDTH-1:0]            box_w_i,
  input  logic [COORD_WIDTH-1:0]            box_h_i,
  input  logic [LABEL_WIDTH-1:0]            class_label_i,
  // kept-list RAM
  output logic                              ram_we_o,
  output logic [AW-1:0]                     ram_waddr_o,
  output logic [BW-1:0]                     ram_wdata_o,
  output logic                              ram_re_o,
  output logic [AW-1:0]                     ram_raddr_o,
  input  logic [BW-1:0]                     ram_rdata_i,
  // result
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              keep_o,
  output logic                              list_full_o,
  output logic [bos_pkg::COUNT_OUT_W-1:0]   kept_count_o
);

  localparam int unsigned C  = COORD_WIDTH;
  localparam int unsigned L  = LABEL_WIDTH;
  localparam int unsigned CW = $clog2(MAX_KEPT + 1);
  localparam int unsigned AR = 2 * C;                 // area width
  localparam int unsigned UW = 2 * C + 1;             // union width
  localparam int unsigned PW = 2 * C + bos_pkg::THR_W + 1;  // compare width

  // 1-d overlap of [a0, ae) and [b0, b0 + bl)
  function automatic logic [C-1:0] overlap(input logic [C-1:0] a0, input logic [C:0] ae,
                                           input logic [C-1:0] b0, input logic [C-1:0] bl);
    logic [C:0] be;
    logic [C:0] lo;
    logic [C:0] hi;
    logic [C:0] diff;
    be   = (C+1)'(b0) + (C+1)'(bl);
    lo   = (a0 > b0) ? (C+1)'(a0) : (C+1)'(b0);
    hi   = (ae < be) ? ae : be;
    diff = hi - lo;
    return (hi > lo) ? diff[C-1:0] : '0;
  endfunction

  // current box
  logic [C-1:0] cur_x_q, cur_y_q, cur_w_q, cur_h_q;
  logic [C:0]   cur_xe_q, cur_ye_q;
  logic [L-1:0] cur_label_q;
  logic [AR-1:0] cur_area_q;

  // list control
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q;
  logic          kill_q;

  // pipeline
  logic          v0_q, v1_q, v2_q, v3_q, v4_q;
  logic          chk1_q, chk2_q, chk3_q, chk4_q;
  logic [C-1:0]  ix1_q, iy1_q;
  logic [AR-1:0] karea1_q;
  logic [AR-1:0] inter2_q, inter3_q, inter4_q;
  logic [UW-1:0] sum2_q;
  logic [UW-1:0] uni3_q;
  logic [PW-1:0] prod4_q;

  // kept entry fields
  logic [C-1:0] k_x, k_y, k_w, k_h;
  logic [L-1:0] k_label;
  logic         hit;

  // result register
  logic                            out_valid_q;
  logic                            keep_q;
  logic                            full_q;
  logic [bos_pkg::COUNT_OUT_W-1:0] kcount_q;
  logic                            keep;
  logic                            has_room;

  // current box capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q     <= box_x_i;
      cur_y_q     <= box_y_i;
      cur_w_q     <= box_w_i;
      cur_h_q     <= box_h_i;
      cur_xe_q    <= (C+1)'(box_x_i) + (C+1)'(box_w_i);
      cur_ye_q    <= (C+1)'(box_y_i) + (C+1)'(box_h_i);
      cur_label_q <= class_label_i;
    end
    cur_area_q <= AR'(cur_w_q) * AR'(cur_h_q);
  end

  // store decision
  assign keep     = !kill_q;
  assign has_room = (count_q < CW'(MAX_KEPT));

  always_comb begin
    count_d = count_q;
    if (cmd_i.load && start_set_i) begin
      count_d = '0;
    end else if (cmd_i.finish && keep && has_room) begin
      count_d = count_q + CW'(1);
    end
  end

  // list count, scan index and suppression flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      kill_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.load) begin
        kill_q <= 1'b0;
      end else if (hit) begin
        kill_q <= 1'b1;
      end
    end
  end

  // kept-list access
  assign ram_re_o    = cmd_i.scan;
  assign ram_raddr_o = idx_q[AW-1:0];
  assign ram_we_o    = cmd_i.finish && keep && has_room;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = {cur_x_q, cur_y_q, cur_w_q, cur_h_q, cur_label_q};

  assign k_x     = ram_rdata_i[BW-1 -: C];
  assign k_y     = ram_rdata_i[BW-1-C -: C];
  assign k_w     = ram_rdata_i[BW-1-2*C -: C];
  assign k_h     = ram_rdata_i[BW-1-3*C -: C];
  assign k_label = ram_rdata_i[L-1:0];

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.scan;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    // overlaps, label filter and kept area
    chk1_q   <= agnostic_i || (k_label == cur_label_q);
    ix1_q    <= overlap(cur_x_q, cur_xe_q, k_x, k_w);
    iy1_q    <= overlap(cur_y_q, cur_ye_q, k_y, k_h);
    karea1_q <= AR'(k_w) * AR'(k_h);
    // intersection and area sum
    chk2_q   <= chk1_q;
    inter2_q <= AR'(ix1_q) * AR'(iy1_q);
    sum2_q   <= UW'(karea1_q) + UW'(cur_area_q);
    // union
    chk3_q   <= chk2_q;
    inter3_q <= inter2_q;
    uni3_q   <= sum2_q - UW'(inter2_q);
    // threshold times union
    chk4_q   <= chk3_q;
    inter4_q <= inter3_q;
    prod4_q  <= PW'(thr_i) * PW'(uni3_q);
  end

  // overlap test: inter * 256 > threshold * union
  assign hit = v4_q && chk4_q && (PW'({inter4_q, 8'h00}) > prod4_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      keep_q   <= keep;
      full_q   <= keep && !has_room;
      kcount_q <= bos_pkg::COUNT_OUT_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign keep_o       = keep_q;
  assign list_full_o  = full_q;
  assign kept_count_o = kcount_q;

  // status
  assign status_o.scan_done  = (idx_q == count_q);
  assign status_o.pipe_empty = !(v0_q || v1_q || v2_q || v3_q || v4_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

@@ src/box_overlap_suppressor.sv @@
// ----------------------------------------------------------------------------
// box_overlap_suppressor
// Greedy non-maximum suppression by intersection over union for boxes that
// arrive sorted by falling score.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one box per transfer; set
//   start_set_i on the first box of a frame to empty the kept list.
//   Output channel (out_valid_o/out_ready_i) returns one verdict per box:
//   keep, list_full and the kept count after that box.
//   Configuration channel (cfg_valid_i/cfg_ready_o) is always ready and
//   writes iou_threshold (index 0) or class_agnostic (index 1); write it
//   only while no box is in flight.
//   Per box, the sweep reads one kept entry per cycle over the N boxes
//   stored in the kept list (at most MAX_KEPT), then the five stage overlap
//   test pipeline drains and the result is registered; the next box is
//   taken only after the result register has been loaded.
//   A stalled receiver holds the result in the output register; the next box
//   is still accepted and processed and waits only to hand over its result.
//   Reset empties the kept list and loads threshold 115 and class-aware mode;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module box_overlap_suppressor #(
  parameter int unsigned MAX_KEPT    = 64,
  parameter int unsigned COORD_WIDTH = 14,
  parameter int unsigned LABEL_WIDTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bos_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bos_pkg::THR_W-1:0]         cfg_data_i,
  // input boxes
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              start_set_i,
  input  logic [COORD_WIDTH-1:0]            box_x_i,
  input  logic [COORD_WIDTH-1:0]            box_y_i,
  input  logic [COORD_WIDTH-1:0]            box_w_i,
  input  logic [COORD_WIDTH-1:0]            box_h_i,
  input  logic [LABEL_WIDTH-1:0]            class_label_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              keep_o,
  output logic                              list_full_o,
  output logic [bos_pkg::COUNT_OUT_W-1:0]   kept_count_o
);

  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned BW = 4 * COORD_WIDTH + LABEL_WIDTH;

  logic [bos_pkg::THR_W-1:0] thr_q;
  logic                      agnostic_q;
  bos_pkg::bos_cmd_t         cmd;
  bos_pkg::bos_status_t      status;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [BW-1:0] ram_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= bos_pkg::THR_RESET;
      agnostic_q <= bos_pkg::AGNOSTIC_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bos_pkg::CFG_IOU_THRESHOLD:  thr_q      <= cfg_data_i;
        bos_pkg::CFG_CLASS_AGNOSTIC: agnostic_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // controller
  bos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  bos_datapath #(
    .MAX_KEPT    (MAX_KEPT),
    .COORD_WIDTH (COORD_WIDTH),
    .LABEL_WIDTH (LABEL_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .thr_i         (thr_q),
    .agnostic_i    (agnostic_q),
    .start_set_i   (start_set_i),
    .box_x_i       (box_x_i),
    .box_y_i       (box_y_i),
    .box_w_i       (box_w_i),
    .box_h_i       (box_h_i),
    .class_label_i (class_label_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .keep_o        (keep_o),
    .list_full_o   (list_full_o),
    .kept_count_o  (kept_count_o)
  );

  // kept-list storage
  bos_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_KEPT)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box overlap suppressor. Boxes are sent as
// frames (clustered, sparse enough to fill the kept list, and fully random),
// and a scoreboard holds the verdicts computed by an in-bench copy of the
// greedy suppression rule. Both handshake sides idle at random, and the
// threshold and class mode are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_KEPT    = 64;
  localparam int unsigned COORD_WIDTH = 14;
  localparam int unsigned LABEL_WIDTH = 8;
  localparam int unsigned COORD_MAX   = (1 << COORD_WIDTH) - 1;

  typedef struct {
    logic                            keep;
    logic                            list_full;
    logic [bos_pkg::COUNT_OUT_W-1:0] kept_count;
  } verdict_t;

  typedef struct {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] w;
    logic [COORD_WIDTH-1:0] h;
    logic [LABEL_WIDTH-1:0] label;
  } box_t;

  typedef enum int unsigned {
    FR_CLUSTER,
    FR_SPARSE,
    FR_WILD
  } frame_kind_e;

  // dut signals
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [bos_pkg::CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [bos_pkg::THR_W-1:0]       cfg_data_i    = '0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_ready_o;
  logic                            start_set_i   = 1'b0;
  logic [COORD_WIDTH-1:0]          box_x_i       = '0;
  logic [COORD_WIDTH-1:0]          box_y_i       = '0;
  logic [COORD_WIDTH-1:0]          box_w_i       = '0;
  logic [COORD_WIDTH-1:0]          box_h_i       = '0;
  logic [LABEL_WIDTH-1:0]          class_label_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i   = 1'b0;
  logic                            keep_o;
  logic                            list_full_o;
  logic [bos_pkg::COUNT_OUT_W-1:0] kept_count_o;

  // predictor state
  box_t                      kept_list [MAX_KEPT];
  int unsigned               kept_n;
  logic [bos_pkg::THR_W-1:0] thr_now;
  logic                      agnostic_now;

  // scoreboard
  verdict_t    verdict_q [$];
  int unsigned fail_count;

  // idling controls
  bit gap_on;
  bit stall_on;

  box_overlap_suppressor u_top (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // overlap of two half-open spans, edges computed in 64 bits like the inputs
  function automatic logic [63:0] span_overlap(logic [63:0] a0, logic [63:0] al,
                                               logic [63:0] b0, logic [63:0] bl);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  // greedy suppression of one box against the kept list, updates the list
  function automatic verdict_t judge_box(logic start, box_t b);
    verdict_t    v;
    logic        hit;
    logic [63:0] inter;
    logic [63:0] uni;
    if (start) kept_n = 0;
    hit = 1'b0;
    for (int unsigned i = 0; i < kept_n; i++) begin
      if (agnostic_now || kept_list[i].label == b.label) begin
        inter = span_overlap(64'(b.x), 64'(b.w), 64'(kept_list[i].x), 64'(kept_list[i].w)) *
                span_overlap(64'(b.y), 64'(b.h), 64'(kept_list[i].y), 64'(kept_list[i].h));
        uni = 64'(b.w) * 64'(b.h) + 64'(kept_list[i].w) * 64'(kept_list[i].h) - inter;
        if (inter * 64'd256 > 64'(thr_now) * uni) hit = 1'b1;
      end
    end
    v.keep      = !hit;
    v.list_full = 1'b0;
    if (!hit) begin
      if (kept_n < MAX_KEPT) begin
        kept_list[kept_n] = b;
        kept_n++;
      end else begin
        v.list_full = 1'b1;
      end
    end
    v.kept_count = bos_pkg::COUNT_OUT_W'(kept_n);
    return v;
  endfunction

  function automatic box_t mk_box(int unsigned x, int unsigned y, int unsigned w,
                                  int unsigned h, int unsigned label);
    box_t b;
    b.x     = COORD_WIDTH'(x);
    b.y     = COORD_WIDTH'(y);
    b.w     = COORD_WIDTH'(w);
    b.h     = COORD_WIDTH'(h);
    b.label = LABEL_WIDTH'(label);
    return b;
  endfunction

  // small random shift, clamped to the coordinate range
  function automatic logic [COORD_WIDTH-1:0] nudge(logic [COORD_WIDTH-1:0] v, int span);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
    if (t < 0) t = 0;
    if (t > int'(COORD_MAX)) t = COORD_MAX;
    return COORD_WIDTH'(t);
  endfunction

  // coordinate with extra weight on both ends of the range
  function automatic logic [COORD_WIDTH-1:0] wild_coord();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return COORD_WIDTH'(COORD_MAX);
    return COORD_WIDTH'($urandom_range(0, COORD_MAX));
  endfunction

  // sender gap, mostly short, a few long
  function automatic int unsigned next_gap();
    int unsigned r;
    if (!gap_on) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(20, 90);
  endfunction

  // one box transfer, verdict predicted at acceptance
  task automatic send_box(logic start, box_t b);
    int unsigned g;
    g = next_gap();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_set_i   <= start;
    box_x_i       <= b.x;
    box_y_i       <= b.y;
    box_w_i       <= b.w;
    box_h_i       <= b.h;
    class_label_i <= b.label;
    do @(posedge clk_i); while (!in_ready_o);
    verdict_q = {verdict_q, judge_box(start, b)};
  endtask

  // stop sending and wait for every outstanding verdict
  task automatic drain_results(int unsigned tail);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // register write, only called while idle
  task automatic write_reg(logic [bos_pkg::CFG_IDX_W-1:0] idx,
                           logic [bos_pkg::THR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bos_pkg::CFG_IOU_THRESHOLD:  thr_now = data;
      bos_pkg::CFG_CLASS_AGNOSTIC: agnostic_now = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one frame of boxes of the given kind
  task automatic run_frame(frame_kind_e kind, int unsigned n);
    box_t        anchor [8];
    int unsigned n_anchor;
    box_t        b;
    logic        st;
    n_anchor = 0;
    for (int unsigned i = 0; i < n; i++) begin
      // occasionally a frame continues the old list or restarts midway
      st = (i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 39) == 0);
      case (kind)
        FR_CLUSTER: begin
          if (n_anchor == 0 || (n_anchor < 8 && $urandom_range(0, 3) == 0)) begin
            b = mk_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                       $urandom_range(16, 3200), $urandom_range(16, 3200),
                       $urandom_range(0, 3));
            anchor[n_anchor] = b;
            n_anchor++;
          end else begin
            b   = anchor[$urandom_range(0, n_anchor - 1)];
            b.x = nudge(b.x, 48);
            b.y = nudge(b.y, 48);
            b.w = nudge(b.w, 48);
            b.h = nudge(b.h, 48);
            if ($urandom_range(0, 3) == 0) b.label = LABEL_WIDTH'($urandom_range(0, 3));
          end
        end
        FR_SPARSE: begin
          b = mk_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, 160), $urandom_range(0, 160),
                     $urandom_range(0, 255));
        end
        default: begin
          b.x     = wild_coord();
          b.y     = wild_coord();
          b.w     = wild_coord();
          b.h     = wild_coord();
          b.label = LABEL_WIDTH'($urandom_range(0, 255));
        end
      endcase
      send_box(st, b);
    end
  endtask

  // reset values: class-aware, threshold 115, zero area and edge boxes
  task automatic test_defaults();
    send_box(1'b1, mk_box(0, 0, 160, 160, 1));
    send_box(1'b0, mk_box(0, 0, 160, 160, 2));
    send_box(1'b0, mk_box(0, 0, 160, 160, 1));
    send_box(1'b0, mk_box(8, 0, 160, 160, 1));
    send_box(1'b0, mk_box(100, 100, 160, 160, 1));
    send_box(1'b0, mk_box(0, 0, 160, 73, 1));
    // two zero-area boxes give a zero union
    send_box(1'b0, mk_box(5, 5, 0, 0, 7));
    send_box(1'b0, mk_box(5, 5, 0, 0, 7));
    send_box(1'b0, mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 255));
    send_box(1'b0, mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 255));
    send_box(1'b1, mk_box(0, 0, COORD_MAX, COORD_MAX, 0));
    send_box(1'b0, mk_box(0, 0, 0, COORD_MAX, 0));
  endtask

  // threshold extremes in class-agnostic mode
  task automatic test_threshold_extremes();
    drain_results(4);
    write_reg(bos_pkg::CFG_IOU_THRESHOLD, '0);
    write_reg(bos_pkg::CFG_CLASS_AGNOSTIC, bos_pkg::THR_W'(1));
    send_box(1'b1, mk_box(0, 0, 320, 320, 5));
    send_box(1'b0, mk_box(300, 300, 320, 320, 9));
    // touching edges do not overlap
    send_box(1'b0, mk_box(320, 0, 320, 320, 9));
    drain_results(4);
    write_reg(bos_pkg::CFG_IOU_THRESHOLD, bos_pkg::THR_W'(255));
    send_box(1'b1, mk_box(0, 0, 320, 320, 5));
    send_box(1'b0, mk_box(0, 0, 320, 320, 5));
    send_box(1'b0, mk_box(0, 0, 320, 319, 6));
    send_box(1'b0, mk_box(16, 0, 320, 320, 5));
  endtask

  // random frames over several register settings
  task automatic test_random_frames();
    int unsigned               sent;
    int unsigned               n;
    int unsigned               r;
    logic [bos_pkg::THR_W-1:0] thr;
    logic                      agn;
    for (int unsigned phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       begin thr = bos_pkg::THR_RESET; agn = 1'b0; end
        1:       begin thr = '0;                 agn = 1'b1; end
        2:       begin thr = 8'd255;             agn = 1'b0; end
        3:       begin thr = 8'd255;             agn = 1'b1; end
        4:       begin thr = bos_pkg::THR_RESET; agn = 1'b1; end
        default: begin
          thr = bos_pkg::THR_W'($urandom_range(0, 255));
          agn = 1'($urandom_range(0, 1));
        end
      endcase
      // one phase runs with no idling on either side
      gap_on   = (phase != 2);
      stall_on = (phase != 2);
      drain_results(4);
      write_reg(bos_pkg::CFG_IOU_THRESHOLD, thr);
      write_reg(bos_pkg::CFG_CLASS_AGNOSTIC, bos_pkg::THR_W'(agn));
      sent = 0;
      while (sent < 198) begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          n = $urandom_range(4, 40);
          run_frame(FR_CLUSTER, n);
        end else if (r < 15) begin
          n = $urandom_range(66, 80);
          run_frame(FR_SPARSE, n);
        end else begin
          n = $urandom_range(3, 20);
          run_frame(FR_WILD, n);
        end
        sent += n;
        // sender holds off until the block has handed over everything
        if ($urandom_range(0, 5) == 0) drain_results(4);
      end
    end
  endtask

  // main sequence
  initial begin
    kept_n       = 0;
    thr_now      = bos_pkg::THR_RESET;
    agnostic_now = bos_pkg::AGNOSTIC_RESET;
    fail_count   = 0;
    gap_on       = 1'b1;
    stall_on     = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_threshold_extremes();
    test_random_frames();
    drain_results(MAX_KEPT + 16);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver stalls, mostly short, a few long
  initial begin : ready_drive
    int unsigned n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (stall_on) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 3);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // compare each verdict transfer with the oldest prediction
  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict with none expected, keep %0b list_full %0b count %0d",
                 $time, keep_o, list_full_o, kept_count_o);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (keep_o !== want.keep) begin
          $display("%0t: keep expected %0b actual %0b", $time, want.keep, keep_o);
          fail_count++;
        end
        if (list_full_o !== want.list_full) begin
          $display("%0t: list_full expected %0b actual %0b", $time, want.list_full,
                   list_full_o);
          fail_count++;
        end
        if (kept_count_o !== want.kept_count) begin
          $display("%0t: kept_count expected %0d actual %0d", $time, want.kept_count,
                   kept_count_o);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #25_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
